### design/bounded_ordered_list_engine_assert.svh
// Assertion macros for the ordered list engine.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define BOLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BOLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BOLE_ASSERT(lbl, prop, msg)
`define BOLE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### design/bole_pkg.sv
`timescale 1ns / 1ps

package bole_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int OPERAND_W    = 32;
    localparam int POS_W        = 5;

    // request function codes; any other code deletes at a position
    localparam logic [1:0] FUNC_INS_HEAD = 2'd0;
    localparam logic [1:0] FUNC_APPEND   = 2'd1;
    localparam logic [1:0] FUNC_DELETE   = 2'd2;

    typedef struct packed {
        logic accept;   // take the request on the input ports
        logic shift;    // one step of the delete compaction
        logic emit;     // issue one result read
    } ctl_cmd_t;

    typedef struct packed {
        logic del_go;      // request is a delete at a valid position
        logic shift_done;  // compaction finishes this cycle
        logic emit_done;   // last result issued this cycle
    } ctl_sts_t;

endpackage

### design/bole_ctrl.sv
`timescale 1ns / 1ps

`include "bounded_ordered_list_engine_assert.svh"

module bole_ctrl
    import bole_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic     busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.del_go ? S_SHIFT : S_EMIT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `BOLE_ASSERT(a_shift_entry, (state_reg == S_SHIFT) |-> ($past(state_reg) == S_SHIFT || $past(cmd.accept)), "compaction entered without a delete request")
    `BOLE_ASSERT(a_busy_after_accept, cmd.accept |=> busy, "engine idle right after taking a request")

endmodule

### design/bole_dp.sv
`timescale 1ns / 1ps

`include "bounded_ordered_list_engine_assert.svh"

module bole_dp
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctl_cmd_t                    cmd,
    output ctl_sts_t                    sts,
    input  logic [1:0]                  func,
    input  logic signed [OPERAND_W-1:0] operand,
    output logic                        strobe,
    output logic signed [OPERAND_W-1:0] item_value,
    output logic [POS_W-1:0]            item_position,
    output logic                        last,
    output logic                        list_empty,
    output logic                        overflow
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // circular buffer: logical position i lives at (head + i) mod CAPACITY
    logic [OPERAND_W-1:0] mem [CAPACITY];
    logic [OPERAND_W-1:0] rdata_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] dst_reg, dst_next;
    logic             ovf_reg, ovf_next;

    logic             out_vld_reg, out_vld_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic             out_last_reg, out_last_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_ovf_reg, out_ovf_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr, head_dec;
    logic [OPERAND_W-1:0] wdata;
    logic [CNT_W-1:0]     idx_inc;
    logic                 full, is_insert, del_go;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign is_insert = (func == FUNC_INS_HEAD) || (func == FUNC_APPEND);
    assign del_go    = !is_insert && !operand[OPERAND_W-1]
                       && ($unsigned(operand) < OPERAND_W'(count_reg));
    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign raddr     = wrap_add(head_reg, cmd.shift ? idx_inc : idx_reg);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        dst_next       = dst_reg;
        ovf_next       = ovf_reg;
        out_vld_next   = 1'b0;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        we             = 1'b0;
        waddr          = head_reg;
        wdata          = operand;
        sts            = '0;
        sts.del_go     = del_go;

        if (cmd.accept)
        begin
            ovf_next  = 1'b0;
            pend_next = 1'b0;
            idx_next  = del_go ? CNT_W'(operand[IDX_W-1:0]) : '0;
            if (is_insert)
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (func == FUNC_INS_HEAD)
                    begin
                        waddr     = head_dec;
                        head_next = head_dec;
                    end
                    else
                    begin
                        waddr = wrap_add(head_reg, count_reg);
                    end
                end
            end
        end

        // compaction: read position j+1 now, write it to j on the next cycle
        if (cmd.shift)
        begin
            if (pend_reg)
            begin
                we    = 1'b1;
                waddr = dst_reg;
                wdata = rdata_reg;
            end
            if (idx_inc < count_reg)
            begin
                pend_next = 1'b1;
                dst_next  = wrap_add(head_reg, idx_reg);
                idx_next  = idx_inc;
            end
            else
            begin
                pend_next      = 1'b0;
                count_next     = count_reg - CNT_W'(1);
                idx_next       = '0;
                sts.shift_done = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_vld_next = 1'b1;
            out_ovf_next = ovf_reg;
            if (count_reg == '0)
            begin
                out_empty_next = 1'b1;
                out_last_next  = 1'b1;
                out_pos_next   = '0;
                sts.emit_done  = 1'b1;
            end
            else
            begin
                out_empty_next = 1'b0;
                out_pos_next   = POS_W'(idx_reg);
                out_last_next  = (idx_inc == count_reg);
                idx_next       = idx_inc;
                sts.emit_done  = (idx_inc == count_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        ovf_reg       <= ovf_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign strobe        = out_vld_reg;
    assign item_value    = out_empty_reg ? '0 : rdata_reg;
    assign item_position = out_pos_reg;
    assign last          = out_last_reg;
    assign list_empty    = out_empty_reg;
    assign overflow      = out_ovf_reg;

    `BOLE_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `BOLE_ASSERT(a_empty_is_last, (out_vld_reg && out_empty_reg) |-> out_last_reg, "empty result not marked last")
    `BOLE_ASSERT(a_burst_gapless, (out_vld_reg && !out_last_reg) |=> out_vld_reg, "gap inside a result burst")

endmodule

### design/bounded_ordered_list_engine.sv
// Ordered list engine: holds up to CAPACITY signed 32-bit entries, head at
// position 0. A request (func, operand) is taken on a rising edge with start
// high and busy low: func 0 inserts operand at the head, 1 appends it at the
// tail, 2 or 3 deletes the entry at position operand (ignored when negative
// or not below the entry count). An insert into a full list is dropped and
// flagged by overflow on every result of that request.
// After each request the whole list is sent head first, one result per
// cycle on strobe, with last on the final one; an empty list gives a single
// result with list_empty and last set. Results cannot be held off.
// Timing: busy is high through compaction and readout. A valid delete at
// position p first compacts the entries behind p toward the head (single
// write port, one entry a cycle) ahead of the readout. The request moves
// the control to compaction or readout, and each result is registered from
// the readout state; results thus trail busy, so the final result may
// appear in the cycle a new request is taken. Reset empties the list at
// once; storage is not cleared.
`timescale 1ns / 1ps

module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic signed [OPERAND_W-1:0] operand,
    output logic                        strobe,
    output logic signed [OPERAND_W-1:0] item_value,
    output logic [POS_W-1:0]            item_position,
    output logic                        last,
    output logic                        list_empty,
    output logic                        overflow
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    bole_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .operand       (operand),
        .strobe        (strobe),
        .item_value    (item_value),
        .item_position (item_position),
        .last          (last),
        .list_empty    (list_empty),
        .overflow      (overflow)
    );

endmodule
